// File: src/dsa_pkg.sv
// Package for the decimal scale aligner: status codes and fixed field widths.
// No dependencies; used by every module in src.
package dsa_pkg;

    localparam int SCALE_W  = 8;
    localparam int COMMON_W = 5;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_SCALE = 2'd1,
        STATUS_CALC_ERR  = 2'd2
    } status_t;

    // Operations of the shared digit unit
    typedef enum logic [1:0] {
        OP_MUL10 = 2'd0,
        OP_DIV10 = 2'd1,
        OP_INC   = 2'd2
    } op_t;

endpackage

// File: src/dsa_digit_unit.sv
// Shared digit unit: times ten with overflow check, one limb step of a divide
// by ten, increment. Depends on dsa_pkg.
module dsa_digit_unit #(
    parameter int MW = 96
) (
    input  dsa_pkg::op_t  op,
    input  logic [MW-1:0] operand,
    input  logic [35:0]   dividend,
    output logic [MW-1:0] result,
    output logic          overflow,
    output logic [31:0]   quotient,
    output logic [3:0]    remainder
);
    import dsa_pkg::*;

    // Reciprocal of ten scaled by 2^39; exact for any dividend below 2^38.
    localparam logic [35:0] RECIP10 = 36'hC_CCCC_CCCD;

    logic [MW+3:0] prod;
    logic [71:0]   recip_prod;

    // One limb step of a long division by ten: the dividend is the running
    // remainder over the next 32-bit limb, so it stays below 10 * 2^32.
    assign recip_prod = dividend * RECIP10;
    assign quotient   = 32'(recip_prod >> 39);
    assign remainder  = 4'(dividend - 36'({quotient, 3'b000}) - 36'({quotient, 1'b0}));

    assign prod = {1'b0, operand, 3'b000} + {3'b000, operand, 1'b0};

    always_comb
    begin
        result = operand;
        overflow = 1'b0;
        case (op)
            OP_MUL10:
            begin
                result = prod[MW-1:0];
                overflow = |prod[MW+3:MW];
            end
            OP_DIV10:
                result = operand;
            OP_INC:
                result = operand + MW'(1);
            default:
                result = operand;
        endcase
    end

endmodule

// File: src/decimal_scale_aligner_top.sv
// Top level of the decimal scale aligner: sequencer, operand registers, output.
// Depends on dsa_pkg and dsa_digit_unit.
//
// Brings two sign-magnitude decimals (mantissa / 10^scale) to one scale. The
// operand with the smaller scale is multiplied by ten step by step while it fits
// in MANTISSA_WIDTH bits; any remaining digit gap d is closed by dividing the
// other operand by 10^d, rounding half to even. One shared digit unit does every
// step, one per clock; a divide by ten walks the mantissa one 32-bit limb per
// clock, NL = ceil(MANTISSA_WIDTH / 32) limbs (3 at the default width). A
// transaction with equal or invalid scales goes straight to the output step;
// one closed by multiplications alone runs them and then the output step; with
// d digits left it runs the multiplications, the checks that 10^d fits, d rounds
// of NL limb divides, one rounding step and one output step. The input is not
// ready while a transaction is in work. A finished result moves to the output
// register and the input is ready again on the next cycle; the sequencer holds
// in its output step only while that register still waits for the receiver. A
// scale above MAX_SCALE returns the mantissas unchanged with status 1; a power
// of ten too wide for the mantissa returns status 2.
module decimal_scale_aligner_top #(
    parameter int MANTISSA_WIDTH = 96,
    parameter int MAX_SCALE      = 28
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_mant_low[63:0], a_mant_high[95:64], a_scale[103:96], a_negative[104],
    // b_mant_low[168:105], b_mant_high[200:169], b_scale[208:201],
    // b_negative[209], zero fill to 215
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // a_out_low[63:0], a_out_high[95:64], a_out_negative[96], b_out_low[160:97],
    // b_out_high[192:161], b_out_negative[193], common_scale[198:194],
    // status[200:199], zero fill to 207
    output logic [207:0] m_tdata
);
    import dsa_pkg::*;

    localparam int MW = MANTISSA_WIDTH;
    localparam int NL = (MW + 31) / 32;           // 32-bit limbs per divide
    localparam int PW = NL * 32;
    localparam int LW = (NL > 1) ? $clog2(NL) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_POW, ST_DIV, ST_ROUND, ST_DONE
    } state_t;

    state_t          state_reg;
    logic [MW-1:0]   a_reg, b_reg, work_reg;
    logic [PW-1:0]   div_reg;         // larger-scale operand during the divide
    logic            a_neg_reg, b_neg_reg;
    logic            a_lo_reg;        // a is the smaller-scale operand
    logic [COMMON_W-1:0] cur_scale_reg;
    logic [SCALE_W-1:0]  left_reg;    // digits still to close
    logic [SCALE_W-1:0]  cnt_reg;
    logic [LW-1:0]   limb_reg;
    logic [3:0]      rem_reg;
    logic [3:0]      top_reg;
    logic            sticky_reg;
    status_t         status_reg;
    logic            out_valid_reg;
    logic [200:0]    out_data_reg;

    op_t             op;
    logic [MW-1:0]   u_in, u_out;
    logic            u_ovf;
    logic [35:0]     u_div_in;
    logic [31:0]     u_quot;
    logic [3:0]      u_rem;

    logic [95:0]     a_in, b_in;
    logic [SCALE_W-1:0] sa, sb;
    logic            round_up;

    assign a_in = s_tdata[95:0];
    assign sa   = s_tdata[103:96];
    assign b_in = s_tdata[200:105];
    assign sb   = s_tdata[208:201];

    // Running remainder over the top limb; the register shifts up one limb a step.
    assign u_div_in = {rem_reg, div_reg[PW-1 -: 32]};

    dsa_digit_unit #(.MW(MW)) u_digit (
        .op       (op),
        .operand  (u_in),
        .dividend (u_div_in),
        .result   (u_out),
        .overflow (u_ovf),
        .quotient (u_quot),
        .remainder(u_rem)
    );

    // Select the operand the shared unit works on this cycle.
    always_comb
    begin
        op = OP_MUL10;
        u_in = a_lo_reg ? a_reg : b_reg;
        case (state_reg)
            ST_POW:   u_in = work_reg;
            ST_DIV:   op = OP_DIV10;
            ST_ROUND:
            begin
                op = OP_INC;
                u_in = div_reg[MW-1:0];
            end
            default:  op = OP_MUL10;
        endcase
    end

    assign round_up = (top_reg > 4'd5) ||
                      (top_reg == 4'd5 && (sticky_reg || div_reg[0]));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Move a finished transaction into the output register once it is free.
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
            begin
                out_data_reg  <= {status_reg, cur_scale_reg, b_neg_reg, 96'(b_reg),
                                  a_neg_reg, 96'(a_reg)};
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        // Load, drop mantissa bits above the width.
                        a_reg      <= MW'(a_in);
                        b_reg      <= MW'(b_in);
                        a_neg_reg  <= s_tdata[104];
                        b_neg_reg  <= s_tdata[209];
                        a_lo_reg   <= sa < sb;
                        top_reg    <= 4'd0;
                        sticky_reg <= 1'b0;
                        status_reg <= STATUS_OK;
                        if (sa > SCALE_W'(MAX_SCALE) || sb > SCALE_W'(MAX_SCALE))
                        begin
                            status_reg    <= STATUS_BAD_SCALE;
                            cur_scale_reg <= '0;
                            state_reg     <= ST_DONE;
                        end
                        else if (sa == sb)
                        begin
                            cur_scale_reg <= COMMON_W'(sa);
                            state_reg     <= ST_DONE;
                        end
                        else
                        begin
                            cur_scale_reg <= COMMON_W'(sa < sb ? sa : sb);
                            left_reg      <= sa < sb ? sb - sa : sa - sb;
                            state_reg     <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    // Advance the smaller-scale operand while it fits.
                    if (left_reg == '0)
                        state_reg <= ST_DONE;
                    else if (u_ovf)
                    begin
                        work_reg  <= MW'(1);
                        cnt_reg   <= left_reg;
                        state_reg <= ST_POW;
                    end
                    else
                    begin
                        if (a_lo_reg)
                            a_reg <= u_out;
                        else
                            b_reg <= u_out;
                        cur_scale_reg <= cur_scale_reg + 1'b1;
                        left_reg      <= left_reg - 1'b1;
                    end
                end
                ST_POW:
                begin
                    // Check that 10^d fits in the mantissa width.
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= left_reg;
                        div_reg   <= PW'(a_lo_reg ? b_reg : a_reg);
                        limb_reg  <= LW'(NL - 1);
                        rem_reg   <= 4'd0;
                        state_reg <= ST_DIV;
                    end
                    else if (u_ovf)
                    begin
                        status_reg <= STATUS_CALC_ERR;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        work_reg <= u_out;
                        cnt_reg  <= cnt_reg - 1'b1;
                    end
                end
                ST_DIV:
                begin
                    // Divide one limb, most significant first, and rotate it in.
                    div_reg <= (div_reg << 32) | PW'(u_quot);
                    if (limb_reg == '0)
                    begin
                        rem_reg  <= 4'd0;
                        limb_reg <= LW'(NL - 1);
                        cnt_reg  <= cnt_reg - 1'b1;
                        if (cnt_reg == SCALE_W'(1))
                        begin
                            top_reg   <= u_rem;
                            state_reg <= ST_ROUND;
                        end
                        else
                            sticky_reg <= sticky_reg | (u_rem != 4'd0);
                    end
                    else
                    begin
                        rem_reg  <= u_rem;
                        limb_reg <= limb_reg - 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    if (a_lo_reg)
                        b_reg <= round_up ? u_out : div_reg[MW-1:0];
                    else
                        a_reg <= round_up ? u_out : div_reg[MW-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hold until the output register takes the result.
                    if (!out_valid_reg || m_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: src/dsa_checker.sv
// Port-level checker for decimal_scale_aligner_top, bound to the top level.
// Depends on dsa_pkg.
module dsa_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [215:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata
);
    import dsa_pkg::*;

    // Handshake outputs are always driven to known levels.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid})) else $error("unknown handshake output");

    // A held result stays stable.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Status is never the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[200:199] != 2'd3) else $error("bad status code");

    // Bad scale reports common scale zero.
    a_bad_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[200:199] == STATUS_BAD_SCALE |-> m_tdata[198:194] == 5'd0)
        else $error("invalid scale with nonzero common scale");

    // Not ready right after an accept.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("ready right after accept");

endmodule

bind decimal_scale_aligner_top dsa_checker u_dsa_checker (.*);

// File: sim/testbench.sv
// Self-checking bench for decimal_scale_aligner_top: table-driven directed cases,
// then random operand pairs checked against a scale-alignment predictor.
// Depends on dsa_pkg and the RTL in src.
`timescale 1ns / 1ps

module testbench;
    import dsa_pkg::*;

    localparam int MW = 96;
    localparam int MAXS = 28;
    localparam int RAND_ITEMS = 1630;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  common_scale;
        logic        b_neg;
        logic [95:0] b_mant;
        logic        a_neg;
        logic [95:0] a_mant;
    } align_res_t;

    typedef struct {
        logic [95:0] a_mant;
        logic [7:0]  a_scale;
        logic        a_neg;
        logic [95:0] b_mant;
        logic [7:0]  b_scale;
        logic        b_neg;
        bit          typed;
        align_res_t  res;
    } case_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;

    align_res_t aligned_q[$];
    int         err_cnt;
    int         got_cnt;
    longint     cyc;
    int         src_idle_pct;
    int         snk_idle_pct;
    bit         hold_sink;
    bit         stim_done;

    decimal_scale_aligner_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Predict one aligned pair; mantissas are kept 128 bits wide to spot overflow.
    function automatic align_res_t align_pair(logic [95:0] am, logic [7:0] as,
                                              logic an, logic [95:0] bm,
                                              logic [7:0] bs, logic bn);
        align_res_t r;
        logic [127:0] lo, gr, t, p;
        int ls, gs, diff, done, d, top;
        bit sticky, ok;
        r.a_neg = an;
        r.b_neg = bn;
        r.status = STATUS_OK;
        r.common_scale = '0;
        r.a_mant = am;
        r.b_mant = bm;
        if (as > MAXS || bs > MAXS)
        begin
            r.status = STATUS_BAD_SCALE;
            return r;
        end
        if (as == bs)
        begin
            r.common_scale = as[4:0];
            return r;
        end
        lo = (as < bs) ? {32'd0, am} : {32'd0, bm};
        gr = (as < bs) ? {32'd0, bm} : {32'd0, am};
        ls = (as < bs) ? as : bs;
        gs = (as < bs) ? bs : as;
        diff = gs - ls;
        done = 0;
        // Grow the smaller-scale operand while the product fits.
        while (done < diff)
        begin
            t = lo * 10;
            if (t[127:MW] != 0)
                break;
            lo = t;
            done++;
        end
        d = diff - done;
        r.common_scale = 5'(ls + done);
        if (d > 0)
        begin
            p = 1;
            ok = 1;
            for (int i = 0; i < d && ok; i++)
            begin
                p = p * 10;
                if (p[127:MW] != 0)
                    ok = 0;
            end
            if (!ok)
                r.status = STATUS_CALC_ERR;
            else
            begin
                sticky = 0;
                top = 0;
                for (int i = 0; i < d; i++)
                begin
                    if (i == d - 1)
                        top = int'(gr % 10);
                    else if (gr % 10 != 0)
                        sticky = 1;
                    gr = gr / 10;
                end
                // Round half to even on the last removed digit.
                if (top > 5 || (top == 5 && (sticky || gr[0])))
                    gr = gr + 1;
            end
        end
        if (as < bs)
        begin
            r.a_mant = lo[95:0];
            r.b_mant = gr[95:0];
        end
        else
        begin
            r.b_mant = lo[95:0];
            r.a_mant = gr[95:0];
        end
        return r;
    endfunction

    // Push one transaction onto the slave side and wait for its acceptance.
    task automatic offer_operands(logic [95:0] am, logic [7:0] as, logic an,
                                  logic [95:0] bm, logic [7:0] bs, logic bn);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, bn, bs, bm, an, as, am};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        aligned_q.push_back(align_pair(am, as, an, bm, bs, bn));
    endtask

    function automatic logic [95:0] rand_mant();
        logic [95:0] m;
        m = {$urandom, $urandom, $urandom};
        // Vary magnitude so both overflow and exact-fit cases occur.
        case ($urandom_range(5))
            0: m = m >> $urandom_range(95);
            1: m = m >> ($urandom_range(40) + 56);
            2: m = 96'($urandom_range(20));
            3: m = '1;
            default: ;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] rand_scale();
        if ($urandom_range(19) == 0)
            return 8'($urandom);
        return 8'($urandom_range(MAXS));
    endfunction

    // Compare the master side against the oldest prediction.
    always @(posedge clk)
    begin
        align_res_t act, exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act = m_tdata[200:0];
            got_cnt++;
            if (aligned_q.size() == 0)
            begin
                $error("result with no prediction pending");
                err_cnt++;
            end
            else
            begin
                exp_r = aligned_q.pop_front();
                if (act.a_mant[63:0] !== exp_r.a_mant[63:0])
                begin
                    $error("a_out_low exp %h act %h", exp_r.a_mant[63:0],
                           act.a_mant[63:0]);
                    err_cnt++;
                end
                if (act.a_mant[95:64] !== exp_r.a_mant[95:64])
                begin
                    $error("a_out_high exp %h act %h", exp_r.a_mant[95:64],
                           act.a_mant[95:64]);
                    err_cnt++;
                end
                if (act.a_neg !== exp_r.a_neg)
                begin
                    $error("a_out_negative exp %b act %b", exp_r.a_neg, act.a_neg);
                    err_cnt++;
                end
                if (act.b_mant[63:0] !== exp_r.b_mant[63:0])
                begin
                    $error("b_out_low exp %h act %h", exp_r.b_mant[63:0],
                           act.b_mant[63:0]);
                    err_cnt++;
                end
                if (act.b_mant[95:64] !== exp_r.b_mant[95:64])
                begin
                    $error("b_out_high exp %h act %h", exp_r.b_mant[95:64],
                           act.b_mant[95:64]);
                    err_cnt++;
                end
                if (act.b_neg !== exp_r.b_neg)
                begin
                    $error("b_out_negative exp %b act %b", exp_r.b_neg, act.b_neg);
                    err_cnt++;
                end
                if (act.common_scale !== exp_r.common_scale)
                begin
                    $error("common_scale exp %0d act %0d", exp_r.common_scale,
                           act.common_scale);
                    err_cnt++;
                end
                if (act.status !== exp_r.status)
                begin
                    $error("status exp %0d act %0d", exp_r.status, act.status);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_sink)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Long sink hold-off counted here while the sender keeps offering.
    initial
    begin
        int n;
        hold_sink = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_sink = 1'b1;
        n = 0;
        while (n < 400)
        begin
            @(posedge clk);
            n++;
        end
        hold_sink = 1'b0;
    end

    // Watchdog and end of run.
    initial
    begin
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cyc);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        case_t tbl[$];
        case_t c;
        align_res_t z;
        logic [95:0] ones;
        int tail;
        ones = '1;
        err_cnt = 0;
        got_cnt = 0;
        stim_done = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        src_idle_pct = 26;
        snk_idle_pct = 66;

        // Directed rows: typed results only where obvious, else predicted.
        z = '0;
        c = '{default: '0};
        c.typed = 1; c.res = z;
        tbl.push_back(c);                               // all zero, equal scales
        c = '{a_mant: ones, a_scale: 28, a_neg: 1, b_mant: ones, b_scale: 28,
              b_neg: 1, typed: 1, res: '0};
        c.res.a_mant = ones; c.res.b_mant = ones; c.res.a_neg = 1; c.res.b_neg = 1;
        c.res.common_scale = 5'd28;
        tbl.push_back(c);                               // max mantissas, max scale
        c = '{a_mant: ones, a_scale: 29, a_neg: 0, b_mant: 5, b_scale: 0,
              b_neg: 1, typed: 1, res: '0};
        c.res.a_mant = ones; c.res.b_mant = 5; c.res.b_neg = 1;
        c.res.status = STATUS_BAD_SCALE;
        tbl.push_back(c);                               // first scale out of range
        c = '{a_mant: 7, a_scale: 3, a_neg: 1, b_mant: 9, b_scale: 255,
              b_neg: 0, typed: 1, res: '0};
        c.res.a_mant = 7; c.res.b_mant = 9; c.res.a_neg = 1;
        c.res.status = STATUS_BAD_SCALE;
        tbl.push_back(c);                               // second scale at 255
        c = '{a_mant: 1, a_scale: 0, a_neg: 0, b_mant: 1, b_scale: 28,
              b_neg: 0, typed: 1, res: '0};
        c.res.a_mant = 96'd10000000000000000000000000000; c.res.b_mant = 1;
        c.res.common_scale = 5'd28;
        tbl.push_back(c);                               // full growth, no division
        // Rounding: halves, above half, below half, sticky, odd/even quotient.
        tbl.push_back('{ones, 0, 0, 96'd25, 1, 0, 0, z});
        tbl.push_back('{ones, 0, 0, 96'd35, 1, 0, 0, z});
        tbl.push_back('{ones, 0, 1, 96'd36, 1, 1, 0, z});
        tbl.push_back('{ones, 0, 0, 96'd34, 1, 0, 0, z});
        tbl.push_back('{ones, 0, 0, 96'd2501, 2, 0, 0, z});
        tbl.push_back('{ones, 0, 0, 96'd2500, 2, 0, 0, z});
        tbl.push_back('{96'd2500, 2, 1, ones, 0, 0, 0, z});
        tbl.push_back('{ones, 0, 0, ones, 28, 1, 0, z});   // divide by 10^28
        tbl.push_back('{ones, 0, 0, ones, 9, 0, 0, z});
        tbl.push_back('{ones >> 1, 5, 1, 96'd123456789, 20, 0, 0, z});
        tbl.push_back('{96'd1 << 95, 1, 0, 96'd0, 27, 1, 0, z});
        tbl.push_back('{96'd999, 28, 0, ones, 0, 1, 0, z}); // b cannot grow, a divided by 10^28
        tbl.push_back('{96'h5555_5555_5555_5555_5555_5555, 12, 1,
                        96'haaaa_aaaa_aaaa_aaaa_aaaa_aaaa, 7, 0, 0, z});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tbl[i])
        begin
            offer_operands(tbl[i].a_mant, tbl[i].a_scale, tbl[i].a_neg,
                           tbl[i].b_mant, tbl[i].b_scale, tbl[i].b_neg);
            // Override the predicted entry with the typed-in one for checking.
            if (tbl[i].typed)
                aligned_q[aligned_q.size() - 1] = tbl[i].res;
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 3)
            begin
                src_idle_pct = 66;
                snk_idle_pct = 26;
            end
            if (i == 2 * RAND_ITEMS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            offer_operands(rand_mant(), rand_scale(), 1'($urandom),
                           rand_mant(), rand_scale(), 1'($urandom));
        end
        s_tvalid <= 1'b0;

        while (aligned_q.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 100)
        begin
            @(posedge clk);
            tail++;
        end
        $display("covered %0d results: range, equal-scale, growth, rounding cases",
                 got_cnt);
        $display("three idling phases plus a long receiver hold-off");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
src/dsa_pkg.sv
src/dsa_digit_unit.sv
src/decimal_scale_aligner_top.sv
src/dsa_checker.sv
sim/testbench.sv
